/* rtl/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mspwm_pkg.sv */
// Types, codes and constants of the multichannel slow PWM table.
package mspwm_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int DUTY_MAX = 100;
  localparam logic [7:0] PIN_NONE = 8'd255;
  localparam int PROD_W = 40;

  localparam logic [3:0] ACT_TICK = 4'd0;
  localparam logic [3:0] ACT_SETUP = 4'd1;
  localparam logic [3:0] ACT_MODIFY = 4'd2;
  localparam logic [3:0] ACT_DELETE = 4'd3;
  localparam logic [3:0] ACT_RESTART = 4'd4;
  localparam logic [3:0] ACT_ENABLE = 4'd5;
  localparam logic [3:0] ACT_DISABLE = 4'd6;
  localparam logic [3:0] ACT_TOGGLE = 4'd7;
  localparam logic [3:0] ACT_EN_ALL = 4'd8;
  localparam logic [3:0] ACT_DIS_ALL = 4'd9;
  localparam logic [3:0] ACT_QUERY = 4'd10;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ARG = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_CHAN = 3'd3;
  localparam logic [2:0] ST_PIN = 3'd4;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] channel;
    logic [7:0] pin;
    logic [31:0] period;
    logic [7:0] duty;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [15:0] levels;
    logic [15:0] start_mask;
    logic [15:0] stop_mask;
    logic is_on;
    logic [4:0] in_use;
  } out_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] period_len;
    logic [31:0] high_len;
    logic [7:0] pin_label;
    logic enabled;
    logic level;
  } chan_t;

  localparam chan_t CHAN_CLEAR = '{start_time: 32'd0, period_len: 32'd0, high_len: 32'd0,
                                   pin_label: PIN_NONE, enabled: 1'b0, level: 1'b0};

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCAN
  } state_t;

endpackage

/* rtl/mspwm_cell.sv */
// One channel cell of the rotating channel ring.
module mspwm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  mspwm_pkg::chan_t  d_in,
  output mspwm_pkg::chan_t  q
);

  mspwm_pkg::chan_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= mspwm_pkg::CHAN_CLEAR;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

/* rtl/mspwm_div.sv */
// Divider by the duty scale, one quotient byte per cycle by reciprocal multiplication.
module mspwm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mspwm_pkg::PROD_W-1:0]  dividend,
  output logic                          idle,
  output logic [31:0]                   quotient
);

  localparam int NDIG = mspwm_pkg::PROD_W / 8;
  localparam int CW = $clog2(NDIG + 1);
  // For a partial dividend below 25600, (x * 5243) >> 19 equals x / 100 rounded down.
  localparam logic [12:0] RECIP = 13'd5243;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic [mspwm_pkg::PROD_W-1:0] sh_r, sh_nxt;
  logic [14:0] trial;
  logic [27:0] prod;
  logic [7:0] qd;

  always_comb begin
    trial = {rem_r, sh_r[mspwm_pkg::PROD_W-1 -: 8]};
    prod = 28'(trial) * 28'(RECIP);
    qd = prod[26:19];
    rem_nxt = 7'(trial - 15'(qd) * 15'(mspwm_pkg::DUTY_MAX));
    sh_nxt = {sh_r[mspwm_pkg::PROD_W-9:0], qd};
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NDIG);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      sh_r <= sh_nxt;
    end
  end

  assign idle = (cnt_r == '0);
  assign quotient = sh_r[31:0];

endmodule

/* rtl/multichannel_slow_pwm_table_top.sv */
// Top level of the multichannel slow PWM table with its channel ring and control.
// A transaction is taken only in the idle state and walks the whole channel ring once;
// setup or modify with valid arguments first passes the multiply and divide states.
// The result is registered when the last channel steps; a new transaction waits until then.
// The on time comes from a divider that produces one quotient byte per cycle.
// Synchronous active-low reset clears the time counter, all channels and the count in use.
`include "assert_macros.svh"
module multichannel_slow_pwm_table_top #(
  parameter int CHANNELS = mspwm_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mspwm_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mspwm_pkg::out_t   out_data
);

  localparam int KW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mspwm_pkg::state_t state_r, state_nxt;
  mspwm_pkg::chan_t cq [CHANNELS];
  mspwm_pkg::chan_t cd [CHANNELS];
  mspwm_pkg::chan_t head_new;

  logic [31:0] now_r;
  logic [4:0] used_r, used_nxt;
  logic [KW-1:0] k_r;
  logic [3:0] act_r, ch_r;
  logic [7:0] pin_r, duty_r;
  logic [31:0] per_r, hl_r;
  logic chok_r, setup_ok_r, found_r, found_nxt, ison_r, ison_nxt;
  logic [2:0] status_r, status_nxt, status_init;
  logic [3:0] slot_r, slot_nxt;
  logic [15:0] lv_r, lv_nxt, st_r, st_nxt, sp_r, sp_nxt;
  mspwm_pkg::out_t out_r;
  logic out_valid_r;

  logic accept, last, step, div_start, div_idle;
  logic args_ok, in_chok, sel;
  logic [31:0] el, quotient;

  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_ring
      if (gi == CHANNELS - 1) begin : g_tail
        assign cd[gi] = head_new;
      end else begin : g_mid
        assign cd[gi] = cq[gi+1];
      end
      mspwm_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (step),
        .d_in  (cd[gi]),
        .q     (cq[gi])
      );
    end
  endgenerate

  mspwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mspwm_pkg::PROD_W'(per_r) * mspwm_pkg::PROD_W'(duty_r)),
    .idle     (div_idle),
    .quotient (quotient)
  );

  assign accept = in_valid && !in_stall;
  assign args_ok = (in_data.period != 32'd0) && (in_data.duty <= 8'(mspwm_pkg::DUTY_MAX));
  assign in_chok = {1'b0, in_data.channel} < 5'(CHANNELS);
  assign last = (k_r == KW'(CHANNELS - 1));

  always_comb begin
    in_stall = 1'b1;
    div_start = 1'b0;
    step = 1'b0;
    unique case (state_r)
      mspwm_pkg::S_IDLE: in_stall = 1'b0;
      mspwm_pkg::S_MUL: div_start = 1'b1;
      mspwm_pkg::S_DIV: ;
      mspwm_pkg::S_SCAN: step = !last || !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mspwm_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_data.action == mspwm_pkg::ACT_SETUP ||
               in_data.action == mspwm_pkg::ACT_MODIFY) && args_ok) begin
            state_nxt = mspwm_pkg::S_MUL;
          end else begin
            state_nxt = mspwm_pkg::S_SCAN;
          end
        end
      end
      mspwm_pkg::S_MUL: state_nxt = mspwm_pkg::S_DIV;
      mspwm_pkg::S_DIV: if (div_idle) state_nxt = mspwm_pkg::S_SCAN;
      mspwm_pkg::S_SCAN: if (step && last) state_nxt = mspwm_pkg::S_IDLE;
      default: state_nxt = mspwm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    status_init = mspwm_pkg::ST_OK;
    unique case (in_data.action) inside
      mspwm_pkg::ACT_SETUP: begin
        status_init = !args_ok ? mspwm_pkg::ST_BAD_ARG : mspwm_pkg::ST_FULL;
      end
      mspwm_pkg::ACT_MODIFY: begin
        if (!args_ok) status_init = mspwm_pkg::ST_BAD_ARG;
        else if (!in_chok) status_init = mspwm_pkg::ST_BAD_CHAN;
      end
      mspwm_pkg::ACT_DELETE, mspwm_pkg::ACT_RESTART, mspwm_pkg::ACT_ENABLE,
      mspwm_pkg::ACT_DISABLE, mspwm_pkg::ACT_TOGGLE, mspwm_pkg::ACT_QUERY: begin
        if (!in_chok) status_init = mspwm_pkg::ST_BAD_CHAN;
      end
      default: ;
    endcase
  end

  always_comb begin
    head_new = cq[0];
    found_nxt = found_r;
    status_nxt = status_r;
    slot_nxt = slot_r;
    ison_nxt = ison_r;
    used_nxt = used_r;
    st_nxt = st_r;
    sp_nxt = sp_r;
    sel = chok_r && (ch_r == 4'(k_r));
    el = now_r - cq[0].start_time;
    unique case (act_r)
      mspwm_pkg::ACT_TICK: begin
        if (cq[0].enabled) begin
          if (el <= cq[0].high_len) begin
            if (!cq[0].level) begin
              head_new.level = 1'b1;
              st_nxt[k_r] = 1'b1;
            end
          end else if (el < cq[0].period_len) begin
            if (cq[0].level) begin
              head_new.level = 1'b0;
              sp_nxt[k_r] = 1'b1;
            end
          end else begin
            head_new.start_time = now_r;
          end
        end
      end
      mspwm_pkg::ACT_SETUP: begin
        if (setup_ok_r && !found_r && cq[0].period_len == 32'd0 && !cq[0].enabled) begin
          head_new = '{start_time: now_r, period_len: per_r, high_len: hl_r,
                       pin_label: pin_r, enabled: 1'b1, level: 1'b1};
          found_nxt = 1'b1;
          status_nxt = mspwm_pkg::ST_OK;
          slot_nxt = 4'(k_r);
          used_nxt = used_r + 5'd1;
        end
      end
      mspwm_pkg::ACT_MODIFY: begin
        if (sel && status_r == mspwm_pkg::ST_OK) begin
          if (cq[0].pin_label != pin_r) begin
            status_nxt = mspwm_pkg::ST_PIN;
          end else begin
            head_new.period_len = per_r;
            head_new.high_len = hl_r;
            head_new.level = 1'b1;
            head_new.start_time = now_r;
          end
        end
      end
      mspwm_pkg::ACT_DELETE: begin
        if (sel && used_r != 5'd0 && cq[0].pin_label != mspwm_pkg::PIN_NONE &&
            cq[0].period_len != 32'd0) begin
          head_new = mspwm_pkg::CHAN_CLEAR;
          used_nxt = used_r - 5'd1;
        end
      end
      mspwm_pkg::ACT_RESTART: if (sel) head_new.start_time = now_r;
      mspwm_pkg::ACT_ENABLE: if (sel) head_new.enabled = 1'b1;
      mspwm_pkg::ACT_DISABLE: if (sel) head_new.enabled = 1'b0;
      mspwm_pkg::ACT_TOGGLE: if (sel) head_new.enabled = !cq[0].enabled;
      mspwm_pkg::ACT_QUERY: if (sel) ison_nxt = cq[0].enabled;
      mspwm_pkg::ACT_EN_ALL: if (cq[0].period_len != 32'd0) head_new.enabled = 1'b1;
      mspwm_pkg::ACT_DIS_ALL: if (cq[0].period_len != 32'd0) head_new.enabled = 1'b0;
      default: ;
    endcase
    lv_nxt = lv_r;
    lv_nxt[k_r] = head_new.level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspwm_pkg::S_IDLE;
      now_r <= '0;
      used_r <= '0;
      k_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_data.action == mspwm_pkg::ACT_TICK) begin
        now_r <= now_r + 32'd1;
      end
      if (step) begin
        used_r <= used_nxt;
        k_r <= last ? '0 : k_r + KW'(1);
      end
      if (step && last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_data.action;
      ch_r <= in_data.channel;
      pin_r <= in_data.pin;
      per_r <= in_data.period;
      duty_r <= in_data.duty;
      chok_r <= in_chok;
      found_r <= 1'b0;
      ison_r <= 1'b0;
      lv_r <= '0;
      st_r <= '0;
      sp_r <= '0;
      setup_ok_r <= args_ok && (used_r < 5'(CHANNELS));
      slot_r <= (in_data.action == mspwm_pkg::ACT_SETUP) ? 4'd0 : in_data.channel;
      status_r <= status_init;
    end else if (step) begin
      found_r <= found_nxt;
      status_r <= status_nxt;
      slot_r <= slot_nxt;
      ison_r <= ison_nxt;
      lv_r <= lv_nxt;
      st_r <= st_nxt;
      sp_r <= sp_nxt;
    end
    if (state_r == mspwm_pkg::S_DIV && div_idle) begin
      hl_r <= quotient;
    end
    if (step && last) begin
      out_r <= '{status: status_nxt, slot: slot_nxt, levels: lv_nxt, start_mask: st_nxt,
                 stop_mask: sp_nxt, is_on: ison_nxt, in_use: used_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `ASSERT_SAME(a_in_use_bound, out_valid_r, out_r.in_use <= 5'(CHANNELS), "in_use above channel count")
  `ASSERT_SAME(a_status_code, out_valid_r, out_r.status <= mspwm_pkg::ST_PIN, "undefined status code")
  `ASSERT_NEXT(a_busy_after_accept, accept, state_r != mspwm_pkg::S_IDLE, "accepted while idle stays")

endmodule

/* sim/tb_multichannel_slow_pwm_table_top.sv */
// Testbench of the multichannel slow PWM table: directed table, random actions, predicted results.
`timescale 1ns / 1ps
module tb_multichannel_slow_pwm_table_top;

  localparam int NCH = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mspwm_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  mspwm_pkg::out_t out_data;

  multichannel_slow_pwm_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    mspwm_pkg::in_t item;
    bit has_exp;
    mspwm_pkg::out_t exp;
  } row_t;

  mspwm_pkg::chan_t pwm_chan[NCH];
  logic [31:0] pwm_now;
  logic [4:0] pwm_used;
  mspwm_pkg::out_t expected_q[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int phase_no;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] on_len(logic [31:0] per, logic [7:0] duty);
    logic [39:0] prod;
    prod = 40'(per) * 40'(duty);
    return 32'(prod / 40'd100);
  endfunction

  function automatic mspwm_pkg::out_t pwm_predict(mspwm_pkg::in_t it);
    mspwm_pkg::out_t r;
    logic [31:0] el;
    bit args_ok;
    bit chan_ok;
    bit found;
    r = '0;
    r.slot = it.channel;
    args_ok = (it.period != 0) && (it.duty <= 8'd100);
    chan_ok = (32'(it.channel) < NCH);
    case (it.action) inside
      mspwm_pkg::ACT_TICK: begin
        pwm_now = pwm_now + 32'd1;
        for (int c = 0; c < NCH; c++) begin
          if (pwm_chan[c].enabled) begin
            el = pwm_now - pwm_chan[c].start_time;
            if (el <= pwm_chan[c].high_len) begin
              if (!pwm_chan[c].level) begin
                pwm_chan[c].level = 1'b1;
                r.start_mask[c] = 1'b1;
              end
            end else if (el < pwm_chan[c].period_len) begin
              if (pwm_chan[c].level) begin
                pwm_chan[c].level = 1'b0;
                r.stop_mask[c] = 1'b1;
              end
            end else begin
              pwm_chan[c].start_time = pwm_now;
            end
          end
        end
      end
      mspwm_pkg::ACT_SETUP: begin
        r.slot = '0;
        found = 1'b0;
        if (!args_ok) r.status = mspwm_pkg::ST_BAD_ARG;
        else begin
          r.status = mspwm_pkg::ST_FULL;
          if (pwm_used < NCH) begin
            for (int c = 0; c < NCH; c++) begin
              if (!found && pwm_chan[c].period_len == 0 && !pwm_chan[c].enabled) begin
                found = 1'b1;
                pwm_chan[c].pin_label = it.pin;
                pwm_chan[c].period_len = it.period;
                pwm_chan[c].high_len = on_len(it.period, it.duty);
                pwm_chan[c].level = 1'b1;
                pwm_chan[c].start_time = pwm_now;
                pwm_chan[c].enabled = 1'b1;
                pwm_used++;
                r.slot = 4'(c);
                r.status = mspwm_pkg::ST_OK;
              end
            end
          end
        end
      end
      mspwm_pkg::ACT_MODIFY: begin
        if (!args_ok) r.status = mspwm_pkg::ST_BAD_ARG;
        else if (!chan_ok) r.status = mspwm_pkg::ST_BAD_CHAN;
        else if (pwm_chan[it.channel].pin_label != it.pin) r.status = mspwm_pkg::ST_PIN;
        else begin
          pwm_chan[it.channel].period_len = it.period;
          pwm_chan[it.channel].high_len = on_len(it.period, it.duty);
          pwm_chan[it.channel].level = 1'b1;
          pwm_chan[it.channel].start_time = pwm_now;
        end
      end
      mspwm_pkg::ACT_DELETE: begin
        if (!chan_ok) r.status = mspwm_pkg::ST_BAD_CHAN;
        else if (pwm_used != 0 && pwm_chan[it.channel].pin_label != mspwm_pkg::PIN_NONE &&
            pwm_chan[it.channel].period_len != 0) begin
          pwm_chan[it.channel] = mspwm_pkg::CHAN_CLEAR;
          pwm_used--;
        end
      end
      mspwm_pkg::ACT_RESTART, mspwm_pkg::ACT_ENABLE, mspwm_pkg::ACT_DISABLE,
      mspwm_pkg::ACT_TOGGLE, mspwm_pkg::ACT_QUERY: begin
        if (!chan_ok) r.status = mspwm_pkg::ST_BAD_CHAN;
        else if (it.action == mspwm_pkg::ACT_RESTART)
          pwm_chan[it.channel].start_time = pwm_now;
        else if (it.action == mspwm_pkg::ACT_ENABLE) pwm_chan[it.channel].enabled = 1'b1;
        else if (it.action == mspwm_pkg::ACT_DISABLE) pwm_chan[it.channel].enabled = 1'b0;
        else if (it.action == mspwm_pkg::ACT_TOGGLE)
          pwm_chan[it.channel].enabled = ~pwm_chan[it.channel].enabled;
        else r.is_on = pwm_chan[it.channel].enabled;
      end
      mspwm_pkg::ACT_EN_ALL, mspwm_pkg::ACT_DIS_ALL: begin
        for (int c = 0; c < NCH; c++)
          if (pwm_chan[c].period_len != 0)
            pwm_chan[c].enabled = (it.action == mspwm_pkg::ACT_EN_ALL);
      end
      default: ;
    endcase
    for (int c = 0; c < NCH; c++) r.levels[c] = pwm_chan[c].level;
    r.in_use = pwm_used;
    return r;
  endfunction

  task automatic send_item(mspwm_pkg::in_t it, bit has_exp, mspwm_pkg::out_t exp);
    mspwm_pkg::out_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    p = pwm_predict(it);
    if (has_exp && p !== exp) begin
      $display("%0t: table row mismatch expected %h actual %h", $time, exp, p);
      errors++;
    end
    expected_q.push_back(p);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic mspwm_pkg::in_t mk(logic [3:0] a, logic [3:0] ch, logic [7:0] pin,
                                        logic [31:0] per, logic [7:0] duty);
    mspwm_pkg::in_t it;
    it.action = a;
    it.channel = ch;
    it.pin = pin;
    it.period = per;
    it.duty = duty;
    return it;
  endfunction

  function automatic mspwm_pkg::out_t mo(logic [2:0] st, logic [3:0] slot, logic [15:0] lv,
                                         logic [4:0] used);
    mspwm_pkg::out_t o;
    o = '0;
    o.status = st;
    o.slot = slot;
    o.levels = lv;
    o.in_use = used;
    return o;
  endfunction

  function automatic mspwm_pkg::in_t rand_item();
    mspwm_pkg::in_t it;
    int k;
    it = mspwm_pkg::in_t'({$urandom, $urandom});
    k = $urandom_range(99);
    if (k < 50) it.action = mspwm_pkg::ACT_TICK;
    else if (k < 62) it.action = mspwm_pkg::ACT_SETUP;
    else if (k < 70) it.action = mspwm_pkg::ACT_MODIFY;
    else if (k < 76) it.action = mspwm_pkg::ACT_DELETE;
    else it.action = 4'($urandom_range(15));
    if ($urandom_range(3) != 0) begin
      it.period = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1, 12));
      it.duty = $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(100));
    end
    if (it.action == mspwm_pkg::ACT_MODIFY && $urandom_range(1) == 0)
      it.pin = pwm_chan[it.channel].pin_label;
    else if ($urandom_range(1) == 0) it.pin = 8'($urandom_range(4));
    return it;
  endfunction

  always @(posedge clk) begin
    mspwm_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.status !== e.status || out_data.slot !== e.slot ||
            out_data.levels !== e.levels || out_data.start_mask !== e.start_mask ||
            out_data.stop_mask !== e.stop_mask || out_data.is_on !== e.is_on ||
            out_data.in_use !== e.in_use) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  initial begin
    row_t rows[$];
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    pwm_now = '0;
    pwm_used = '0;
    for (int c = 0; c < NCH; c++) pwm_chan[c] = mspwm_pkg::CHAN_CLEAR;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      '{mk(mspwm_pkg::ACT_QUERY, 4'd15, 8'd0, 32'd0, 8'd0), 1,
        mo(mspwm_pkg::ST_OK, 4'd15, 16'h0, 5'd0)},
      '{mk(mspwm_pkg::ACT_SETUP, 4'd0, 8'd1, 32'd0, 8'd50), 1,
        mo(mspwm_pkg::ST_BAD_ARG, 4'd0, 16'h0, 5'd0)},
      '{mk(mspwm_pkg::ACT_SETUP, 4'd0, 8'd1, 32'd10, 8'd101), 1,
        mo(mspwm_pkg::ST_BAD_ARG, 4'd0, 16'h0, 5'd0)},
      '{mk(mspwm_pkg::ACT_SETUP, 4'd9, 8'd1, 32'hFFFF_FFFF, 8'd100), 1,
        mo(mspwm_pkg::ST_OK, 4'd0, 16'h1, 5'd1)},
      '{mk(mspwm_pkg::ACT_SETUP, 4'd0, 8'd0, 32'd4, 8'd50), 0, '0},
      '{mk(mspwm_pkg::ACT_SETUP, 4'd0, 8'd254, 32'd1, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_MODIFY, 4'd1, 8'd7, 32'd6, 8'd30), 1,
        mo(mspwm_pkg::ST_PIN, 4'd1, 16'h5, 5'd3)},
      '{mk(mspwm_pkg::ACT_MODIFY, 4'd1, 8'd0, 32'd6, 8'd255), 1,
        mo(mspwm_pkg::ST_BAD_ARG, 4'd1, 16'h5, 5'd3)},
      '{mk(mspwm_pkg::ACT_MODIFY, 4'd1, 8'd0, 32'd8, 8'd25), 0, '0},
      '{mk(mspwm_pkg::ACT_MODIFY, 4'd12, 8'd255, 32'd5, 8'd40), 0, '0},
      '{mk(mspwm_pkg::ACT_RESTART, 4'd1, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_DISABLE, 4'd2, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_TOGGLE, 4'd3, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_ENABLE, 4'd4, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_DIS_ALL, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_EN_ALL, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_DELETE, 4'd12, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_DELETE, 4'd1, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_QUERY, 4'd4, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(4'd15, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0},
      '{mk(mspwm_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0}
    };
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);

    // Send more setups than the table has free slots, so that setup reports no free slot.
    for (int i = 0; i < 18; i++)
      send_item(mk(mspwm_pkg::ACT_SETUP, 4'd0, 8'(i), 32'(i + 2), 8'd60), 0, '0);
    for (int i = 0; i < 20; i++)
      send_item(mk(mspwm_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0, 8'd0), 0, '0);

    for (phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 50; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 50; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase_no == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
          for (int i = 0; i < 20; i++) send_item(rand_item(), 0, '0);
        join
      end
      for (int i = 0; i < 90; i++) send_item(rand_item(), 0, '0);
      while (expected_q.size() != 0) @(negedge clk);
      if (phase_no == 2)
        for (int c = 0; c < NCH; c++)
          send_item(mk(mspwm_pkg::ACT_DELETE, 4'(c), 8'd0, 32'd0, 8'd0), 0, '0);
    end

    recv_stall_pct = 0;
    drain = 0;
    while (expected_q.size() != 0 && drain < 100000) begin
      @(negedge clk);
      drain++;
    end
    repeat (100) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_q.size() != 0) $display("%0t: %0d results missing", $time, expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mspwm_pkg.sv
rtl/mspwm_cell.sv
rtl/mspwm_div.sv
rtl/multichannel_slow_pwm_table_top.sv
sim/tb_multichannel_slow_pwm_table_top.sv
